// File: hdl/des_ks_pkg.sv
package des_ks_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned CdW    = 56;
  localparam int unsigned HalfW  = 28;
  localparam int unsigned RkW    = 48;
  localparam int unsigned RoundW = 4;
  localparam int unsigned Rounds = 16;
  localparam logic [RoundW-1:0] LastRound = RoundW'(Rounds - 1);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef logic [CdW-1:0] cd_t;

  typedef struct packed {
    logic valid;
    cd_t  cd;
  } q_head_t;

  localparam logic [6:0] Pc1Tab [CdW] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] Pc2Tab [RkW] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // rounds with a single-bit rotation
  localparam logic [Rounds-1:0] SingleRot = 16'b1000_0001_0000_0011;

  function automatic cd_t pc1(input logic [KeyW-1:0] key);
    cd_t r;
    for (int i = 0; i < CdW; i++) begin
      r[CdW-1-i] = key[KeyW - int'(Pc1Tab[i])];
    end
    return r;
  endfunction

  function automatic logic [RkW-1:0] pc2(input cd_t cd);
    logic [RkW-1:0] r;
    for (int i = 0; i < RkW; i++) begin
      r[RkW-1-i] = cd[CdW - int'(Pc2Tab[i])];
    end
    return r;
  endfunction

endpackage

// File: hdl/des_ks_front.sv
module des_ks_front (
  input  logic                               in_valid_i,
  input  logic [des_ks_pkg::KeyW-1:0]        key_i,
  input  logic                               q_full_i,
  output logic                               in_stall_o,
  output logic                               push_o,
  output des_ks_pkg::cd_t                    push_cd_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign push_cd_o  = des_ks_pkg::pc1(key_i);

endmodule

// File: hdl/des_ks_queue.sv
module des_ks_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  des_ks_pkg::cd_t       push_cd_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output des_ks_pkg::q_head_t   head_o
);

  des_ks_pkg::cd_t                  mem_q [des_ks_pkg::QDepth];
  logic [des_ks_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [des_ks_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [des_ks_pkg::QCntW-1:0]     cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cd_i;
    end
  end

  assign full_o       = (cnt_q == des_ks_pkg::QCntW'(des_ks_pkg::QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cd    = mem_q[rd_ptr_q];

endmodule

// File: hdl/des_ks_back.sv
module des_ks_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  des_ks_pkg::q_head_t                head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [des_ks_pkg::RkW-1:0]         round_key_o,
  output logic [des_ks_pkg::RoundW-1:0]      round_number_o,
  output logic                               last_o
);

  logic                                busy_q, busy_d;
  logic [des_ks_pkg::RoundW-1:0]       round_q, round_d;
  logic [des_ks_pkg::HalfW-1:0]        c_q, c_d, d_q, d_d, c_rot, d_rot;
  logic                                out_valid_q, out_valid_d;
  logic [des_ks_pkg::RkW-1:0]          rk_q;
  logic [des_ks_pkg::RoundW-1:0]       rn_q;
  logic                                last_q;
  logic                                advance, finish, load;

  always_comb begin
    if (des_ks_pkg::SingleRot[round_q]) begin
      c_rot = {c_q[des_ks_pkg::HalfW-2:0], c_q[des_ks_pkg::HalfW-1]};
      d_rot = {d_q[des_ks_pkg::HalfW-2:0], d_q[des_ks_pkg::HalfW-1]};
    end else begin
      c_rot = {c_q[des_ks_pkg::HalfW-3:0], c_q[des_ks_pkg::HalfW-1 -: 2]};
      d_rot = {d_q[des_ks_pkg::HalfW-3:0], d_q[des_ks_pkg::HalfW-1 -: 2]};
    end
  end

  assign advance = busy_q && (!out_valid_q || !out_stall_i);
  assign finish  = advance && (round_q == des_ks_pkg::LastRound);
  assign load    = head_i.valid && (!busy_q || finish);
  assign pop_o   = load;

  always_comb begin
    busy_d      = busy_q;
    round_d     = round_q;
    c_d         = c_q;
    d_d         = d_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      c_d         = c_rot;
      d_d         = d_rot;
      round_d     = round_q + 1'b1;
      if (finish) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      round_d = '0;
      c_d     = head_i.cd[des_ks_pkg::CdW-1 -: des_ks_pkg::HalfW];
      d_d     = head_i.cd[des_ks_pkg::HalfW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    d_q <= d_d;
    if (advance) begin
      rk_q   <= des_ks_pkg::pc2({c_rot, d_rot});
      rn_q   <= round_q;
      last_q <= finish;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign round_key_o    = rk_q;
  assign round_number_o = rn_q;
  assign last_o         = last_q;

endmodule

// File: hdl/des_key_schedule.sv
// DES key schedule.
// Input channel: in_valid_i / in_stall_o carry one 64-bit key word (key_i,
// bit 1 of the standard is the MSB, parity bits ignored).
// Output channel: out_valid_o / out_stall_i carry sixteen round key words
// per key: round_key_o (48 bits after PC2), round_number_o (0 to 15) and
// last_o, high on the sixteenth.
// A key is reduced by PC1 on entry and held in a two-deep queue; the round
// unit takes it from there and produces one round key per cycle, while the
// output does not stall, by rotating the C and D halves, so each key holds
// the round unit for its sixteen rounds. The first round key of a key is
// registered on the output behind the queue entry and the C and D registers.
// While the queue holds the next key, keys follow with no gap on the output.
// When the receiver stalls, the output word holds and the round unit waits;
// the queue keeps taking keys until both entries are full.
// Reset clears the queue, the round unit and the output valid; words in
// flight are dropped.
module des_key_schedule (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [des_ks_pkg::KeyW-1:0]        key_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [des_ks_pkg::RkW-1:0]         round_key_o,
  output logic [des_ks_pkg::RoundW-1:0]      round_number_o,
  output logic                               last_o
);

  logic                 q_full, push, pop;
  des_ks_pkg::cd_t      push_cd;
  des_ks_pkg::q_head_t  head;

  des_ks_front u_front (
    .in_valid_i (in_valid_i),
    .key_i      (key_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .push_cd_o  (push_cd)
  );

  des_ks_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cd_i (push_cd),
    .pop_i     (pop),
    .full_o    (q_full),
    .head_o    (head)
  );

  des_ks_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .round_key_o    (round_key_o),
    .round_number_o (round_number_o),
    .last_o         (last_o)
  );

endmodule

// File: hdl/des_ks_checker.sv
module des_ks_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic [des_ks_pkg::RkW-1:0]         round_key_o,
  input  logic [des_ks_pkg::RoundW-1:0]      round_number_o,
  input  logic                               last_o
);

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(round_key_o) && $stable(round_number_o)
      && $stable(last_o))
    else $error("stalled output word changed");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (round_number_o == des_ks_pkg::LastRound)))
    else $error("last flag does not match round number");

  a_next_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> out_valid_o
      && (round_number_o == $past(round_number_o) + 1'b1))
    else $error("round sequence broken");

endmodule

bind des_key_schedule des_ks_checker u_des_ks_checker (.*);
